// ===== rtl/mrps_pkg.sv =====
// ----------------------------------------------------------------------------
// mrps_pkg
// Types and constants shared by the message-to-radio packet segmenter.
// ----------------------------------------------------------------------------
package mrps_pkg;

    localparam int PACKET_BYTES_DEF = 32;
    localparam int HEADER_BYTES     = 6;
    localparam int CMDQ_DEPTH       = 4;
    localparam int STEP_W           = 3;

    localparam logic [7:0] MARK_FIRST = 8'd255;
    localparam logic [7:0] MARK_NEXT  = 8'd254;
    localparam logic [7:0] MARK_LAST  = 8'd253;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ORPHAN,
        ST_RESTART,
        ST_EMPTY
    } status_t;

    typedef enum logic [1:0] {
        CMD_STATUS,
        CMD_START,
        CMD_DATA
    } cmd_kind_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] topic_len;
        logic [15:0] payload_len;
        logic        retained_flag;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        logic [5:0] packet_length;
        logic       end_of_message;
        logic       last_of_run;
        status_t    status;
    } res_t;

    // lead: restart status word (status/start kinds) or marker (data kind)
    typedef struct packed {
        cmd_kind_t   kind;
        logic        lead;
        logic [7:0]  marker;
        status_t     status;
        logic [15:0] topic_len;
        logic [15:0] payload_len;
        logic        retained_flag;
        logic [7:0]  data_byte;
        logic        eop;
        logic [5:0]  plen;
        logic        eom;
    } cmd_t;

endpackage

// ===== rtl/mrps_front.sv =====
// ----------------------------------------------------------------------------
// mrps_front
// Tracks message and packet position and turns each input word into a command.
// ----------------------------------------------------------------------------
module mrps_front
    import mrps_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  req_t  req,
    output cmd_t  cmd
);

    logic        open_reg, open_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  pos_reg, pos_next;

    logic [16:0] total;
    logic [16:0] rem_dec;
    logic [5:0]  pos_base;
    logic [5:0]  pos_inc;
    logic        eom;
    logic        eop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
            pos_reg  <= pos_next;
        end
    end

    always_comb
    begin
        total    = {1'b0, req.topic_len} + {1'b0, req.payload_len};
        rem_dec  = rem_reg - 17'd1;
        pos_base = (pos_reg == '0) ? 6'd1 : pos_reg;
        pos_inc  = pos_base + 6'd1;
        eom      = (rem_dec == '0);
        eop      = eom || (pos_inc >= 6'(PACKET_BYTES));

        open_next = open_reg;
        rem_next  = rem_reg;
        pos_next  = pos_reg;

        cmd               = '0;
        cmd.kind          = CMD_STATUS;
        cmd.status        = ST_OK;
        cmd.topic_len     = req.topic_len;
        cmd.payload_len   = req.payload_len;
        cmd.retained_flag = req.retained_flag;
        cmd.data_byte     = req.data_byte;

        if (req.req_type == REQ_START)
        begin
            cmd.lead = open_reg;
            if (total == '0)
            begin
                cmd.kind   = CMD_STATUS;
                cmd.status = ST_EMPTY;
                open_next  = 1'b0;
                rem_next   = '0;
                pos_next   = '0;
            end
            else
            begin
                cmd.kind   = CMD_START;
                cmd.marker = (total <= 17'(PACKET_BYTES - HEADER_BYTES)) ? MARK_LAST
                                                                        : MARK_FIRST;
                open_next  = 1'b1;
                rem_next   = total;
                pos_next   = 6'(HEADER_BYTES);
            end
        end
        else if (!open_reg)
        begin
            cmd.kind   = CMD_STATUS;
            cmd.status = ST_ORPHAN;
        end
        else
        begin
            cmd.kind   = CMD_DATA;
            cmd.lead   = (pos_reg == '0);
            cmd.marker = (rem_reg <= 17'(PACKET_BYTES - 1)) ? MARK_LAST : MARK_NEXT;
            cmd.eom    = eom;
            cmd.eop    = eop;
            cmd.plen   = eop ? pos_inc : '0;
            rem_next   = rem_dec;
            pos_next   = eop ? '0 : pos_inc;
            if (eom)
            begin
                open_next = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/mrps_cmdq.sv =====
// ----------------------------------------------------------------------------
// mrps_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mrps_cmdq
    import mrps_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wdata,
    output logic full,
    input  logic rd,
    output cmd_t rdata,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/mrps_back.sv =====
// ----------------------------------------------------------------------------
// mrps_back
// Expands each command into its result words into an output register, one
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module mrps_back
    import mrps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic q_empty,
    output logic q_pop,
    output res_t res,
    output logic empty,
    input  logic pop
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] pos;
    logic              valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              load;
    logic              advance;

    assign load    = !valid_reg || pop;
    assign advance = load && !q_empty;
    assign q_pop   = advance && (step_reg == last_step);
    assign res     = res_reg;
    assign empty   = !valid_reg;

    always_comb
    begin
        pos       = step_reg - STEP_W'(cmd.lead);
        last_step = (cmd.kind == CMD_START) ? STEP_W'(HEADER_BYTES - 1) + STEP_W'(cmd.lead)
                                            : STEP_W'(cmd.lead);
        res_next             = '0;
        res_next.status      = ST_OK;
        res_next.last_of_run = (step_reg == last_step);

        if (cmd.lead && step_reg == '0)
        begin
            if (cmd.kind == CMD_DATA)
            begin
                res_next.out_byte = cmd.marker;
            end
            else
            begin
                res_next.status = ST_RESTART;
            end
        end
        else
        begin
            case (cmd.kind)
                CMD_STATUS:
                begin
                    res_next.status = cmd.status;
                end
                CMD_START:
                begin
                    case (pos)
                        3'd0:    res_next.out_byte = cmd.marker;
                        3'd1:    res_next.out_byte = cmd.topic_len[7:0];
                        3'd2:    res_next.out_byte = cmd.topic_len[15:8];
                        3'd3:    res_next.out_byte = cmd.payload_len[7:0];
                        3'd4:    res_next.out_byte = cmd.payload_len[15:8];
                        default: res_next.out_byte = {7'd0, cmd.retained_flag};
                    endcase
                end
                CMD_DATA:
                begin
                    res_next.out_byte       = cmd.data_byte;
                    res_next.end_of_packet  = cmd.eop;
                    res_next.packet_length  = cmd.plen;
                    res_next.end_of_message = cmd.eom;
                end
                default:
                begin
                    res_next.status = cmd.status;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                step_reg  <= q_pop ? '0 : step_reg + STEP_W'(1);
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/message_to_radio_packet_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// message_to_radio_packet_segmenter_unit
// Cuts a message into radio packets with markers, header and packet lengths.
// ----------------------------------------------------------------------------
// A word is taken every cycle while the 4-entry command queue has room; the
// result sequencer then sends one result word per cycle while not stalled by
// pop: a data word gives 1 word, or 2 when it opens a packet (marker first);
// a start word gives 6, or 7 after a restart; status words give 1, or 2 after
// a restart. Unstalled, the sustained rate is one data byte per cycle, set by
// the single output port, with header and marker words taking extra cycles.
module message_to_radio_packet_segmenter_unit
    import mrps_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output res_t res
);

    cmd_t fe_cmd;
    cmd_t q_cmd;
    logic accept;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    mrps_front #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cmd    (fe_cmd)
    );

    mrps_cmdq #(
        .DEPTH(CMDQ_DEPTH)
    ) u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (accept),
        .wdata  (fe_cmd),
        .full   (full),
        .rd     (q_pop),
        .rdata  (q_cmd),
        .empty  (q_empty)
    );

    mrps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .res     (res),
        .empty   (empty),
        .pop     (pop)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue popped while empty");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res.status != ST_OK) |->
            (res.out_byte == 8'd0 && !res.end_of_packet && !res.end_of_message))
        else $error("status word carries packet data");

    a_eom_eop: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res.end_of_message) |-> (res.end_of_packet && res.last_of_run))
        else $error("end of message without end of packet");

    a_eop_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res.end_of_packet) |->
            (res.packet_length != 6'd0 && res.packet_length <= 6'(PACKET_BYTES)))
        else $error("bad packet length");

endmodule
